### hw/rtl/lowest_free_slot_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// lowest free slot allocator assertion macros
// shared property forms for the allocator checks, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define LFSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// shared sizes, request codes and interface structs of the slot allocator
// ----------------------------------------------------------------------------
package lfsa_pkg;

   localparam int MAX_TASKS = 1024;
   localparam int MAX_SLOTS = 256;

   localparam int TASK_W = $clog2(MAX_TASKS);
   localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

   // free map searched in groups of GRP_W bits
   localparam int GRP_W   = 16;
   localparam int LIDX_W  = $clog2(GRP_W);
   localparam int NUM_GRP = (MAX_SLOTS + GRP_W - 1) / GRP_W;
   localparam int GIDX_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int MAP_W   = NUM_GRP * GRP_W;
   localparam int MAP_IDX_W = GIDX_W + LIDX_W;

   typedef enum logic {
      OP_START = 1'b0,
      OP_END   = 1'b1
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [TASK_W-1:0] task_id;
   } req_entry_type;

   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

### hw/rtl/lfsa_front.sv
// ----------------------------------------------------------------------------
// lfsa_front
// request intake: classifies start and end events into a two-entry queue
// ----------------------------------------------------------------------------
module lfsa_front
   import lfsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic            req_kind,
   input  logic [9:0]      req_task_req,
   input  back_status_type back_status,
   output queue_head_type  queue_head
);

   req_entry_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   logic          pop;
   req_entry_type new_entry;

   assign busy = (count_ff == 2'd2) || back_status.clearing;
   assign push = start && !busy;
   assign pop  = back_status.pop;

   always_comb begin
      new_entry.op      = req_kind ? OP_END : OP_START;
      new_entry.task_id = TASK_W'(req_task_req);
   end

   assign queue_head.valid = (count_ff != 2'd0);
   assign queue_head.entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

### hw/rtl/lfsa_back.sv
// ----------------------------------------------------------------------------
// lfsa_back
// request execution: slot table, free map search, open count and responses
// ----------------------------------------------------------------------------
module lfsa_back
   import lfsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  queue_head_type  queue_head,
   output back_status_type back_status,
   output logic            rsp_valid,
   output logic [8:0]      rsp_slot,
   output logic [8:0]      rsp_slots_opened,
   output logic            rsp_full_error
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_FETCH,
      S_EXEC
   } state_type;

   state_type         state_ff;
   logic [TASK_W-1:0] clr_cnt_ff;
   logic [MAP_W-1:0]  free_map_ff;
   logic [SLOT_W-1:0] opened_ff;
   req_entry_type     cur_ff;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_err_ff;

   logic [SLOT_W-1:0] slot_mem [MAX_TASKS];
   logic [SLOT_W-1:0] rd_data_ff;

   logic              grp_any_ff [NUM_GRP];
   logic [LIDX_W-1:0] grp_low_ff [NUM_GRP];
   logic              grp_any_in [NUM_GRP];
   logic [LIDX_W-1:0] grp_low_in [NUM_GRP];

   logic                 pop;
   logic                 found;
   logic [GIDX_W-1:0]    pick_grp;
   logic [MAP_IDX_W-1:0] pick_idx;
   logic [MAP_IDX_W-1:0] rel_idx;
   logic [SLOT_W-1:0]    opened_inc;

   logic              mem_we;
   logic [TASK_W-1:0] mem_addr;
   logic [SLOT_W-1:0] mem_wdata;

   logic [SLOT_W-1:0] exec_slot;
   logic              exec_err;

   assign pop = (state_ff == S_FETCH) && queue_head.valid;
   assign back_status.pop      = pop;
   assign back_status.clearing = (state_ff == S_CLEAR);

   // per-group any bit and lowest set position
   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_any_in[g] = |free_map_ff[g*GRP_W +: GRP_W];
         grp_low_in[g] = '0;
         for (int i = GRP_W - 1; i >= 0; i--) begin
            if (free_map_ff[g*GRP_W + i]) begin
               grp_low_in[g] = LIDX_W'(i);
            end
         end
      end
   end

   // lowest group with a released slot
   always_comb begin
      found    = 1'b0;
      pick_grp = '0;
      for (int g = NUM_GRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found    = 1'b1;
            pick_grp = GIDX_W'(g);
         end
      end
      pick_idx = {pick_grp, grp_low_ff[pick_grp]};
   end

   assign rel_idx    = MAP_IDX_W'(rd_data_ff - SLOT_W'(1));
   assign opened_inc = opened_ff + SLOT_W'(1);

   always_comb begin
      exec_slot = '0;
      exec_err  = 1'b0;
      if (cur_ff.op == OP_START) begin
         if (found) begin
            exec_slot = SLOT_W'(pick_idx) + SLOT_W'(1);
         end else if (opened_ff < SLOT_W'(MAX_SLOTS)) begin
            exec_slot = opened_inc;
         end else begin
            exec_err = 1'b1;
         end
      end else begin
         exec_slot = rd_data_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = cur_ff.task_id;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         S_EXEC: begin
            mem_we    = 1'b1;
            mem_wdata = (cur_ff.op == OP_START) ? exec_slot : '0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= slot_mem[queue_head.entry.task_id];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= queue_head.entry;
         for (int g = 0; g < NUM_GRP; g++) begin
            grp_any_ff[g] <= grp_any_in[g];
            grp_low_ff[g] <= grp_low_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         free_map_ff  <= '0;
         opened_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_slot_ff  <= '0;
         rsp_err_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + TASK_W'(1);
               if (clr_cnt_ff == TASK_W'(MAX_TASKS - 1)) begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (queue_head.valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff     <= S_FETCH;
               rsp_valid_ff <= 1'b1;
               rsp_slot_ff  <= exec_slot;
               rsp_err_ff   <= exec_err;
               if (cur_ff.op == OP_START) begin
                  if (found) begin
                     free_map_ff[pick_idx] <= 1'b0;
                  end else if (!exec_err) begin
                     opened_ff <= opened_inc;
                  end
               end else if (rd_data_ff != '0) begin
                  free_map_ff[rel_idx] <= 1'b1;
               end
            end
            default: state_ff <= S_FETCH;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = 9'(rsp_slot_ff);
   assign rsp_slots_opened = 9'(opened_ff);
   assign rsp_full_error   = rsp_err_ff;

endmodule

### hw/rtl/lowest_free_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_core
// hands each starting task the lowest released slot, or opens a new one
// ----------------------------------------------------------------------------
// a request is taken at a rising edge with start high and busy low; req_kind
// selects task start (0) or task end (1), req_task_req names the task.
// every request gives one response, shown on the rsp_ ports for one cycle
// with rsp_valid high; the receiver cannot hold responses off.
// a start returns the slot assigned and raises rsp_full_error when all
// slots are open and none is released; an end returns the slot it released.
// rsp_slots_opened is the count of slots opened after the request.
// from accept, a request is held in the queue, then in the fetch registers with
// its slot table read, then in the response registers after the free map pick
// and table write in the execute step; the next request leaves the queue only
// after that execute step. a two-entry request queue absorbs back-to-back
// requests; busy rises when it is full.
// after reset the slot table is cleared one entry a cycle: busy stays high
// until all 1024 entries are cleared, and no request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "lowest_free_slot_allocator_core_defines.svh"

module lowest_free_slot_allocator_core
   import lfsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [9:0] req_task_req,
   output logic       rsp_valid,
   output logic [8:0] rsp_slot,
   output logic [8:0] rsp_slots_opened,
   output logic       rsp_full_error
);

   back_status_type back_status;
   queue_head_type  queue_head;

   lfsa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_task_req (req_task_req),
      .back_status  (back_status),
      .queue_head   (queue_head)
   );

   lfsa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_head       (queue_head),
      .back_status      (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_slot         (rsp_slot),
      .rsp_slots_opened (rsp_slots_opened),
      .rsp_full_error   (rsp_full_error)
   );

   `LFSA_ASSERT_NOW(a_err_no_slot, rsp_valid && rsp_full_error, rsp_slot == 9'd0, "error with slot")
   `LFSA_ASSERT_NOW(a_err_all_open, rsp_valid && rsp_full_error, rsp_slots_opened == 9'(MAX_SLOTS), "error before all slots open")
   `LFSA_ASSERT_NOW(a_clear_busy, back_status.clearing, busy && !back_status.pop, "request during clear")
   `LFSA_ASSERT_NEXT(a_rsp_spacing, rsp_valid, !rsp_valid, "responses back to back")

endmodule
